### design/page_translate_lru_unit_macros.svh
// ----------------------------------------------------------------------------
// Page translation unit: assertion macros
// Wrappers for the concurrent checks of the translation unit. Defining
// ASSERT_OFF compiles them away.
// ----------------------------------------------------------------------------
`ifndef PAGE_TRANSLATE_LRU_UNIT_MACROS_SVH
`define PAGE_TRANSLATE_LRU_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked at every rising edge outside reset.
`define PTL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("page_translate_lru_unit: same-cycle check failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define PTL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("page_translate_lru_unit: next-cycle check failed");
`else
`define PTL_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PTL_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### design/ptl_pkg.sv
// ----------------------------------------------------------------------------
// Page translation unit package
// Shared constants, register codes, controller/datapath interface types.
// ----------------------------------------------------------------------------
package ptl_pkg;

	// Default sizes of the unit.
	localparam int MAX_PAGES  = 256;
	localparam int MAX_FRAMES = 128;
	localparam int ADDR_BITS  = 32;

	// Width of the saturating access clock and of the page stamps.
	localparam int STAMP_W = 32;

	// Configuration port.
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 9;
	localparam int PAGE_SHIFT_W = 5;
	localparam int PAGE_CNT_W   = 9;
	localparam int FRAME_CNT_W  = 8;

	localparam logic [PAGE_SHIFT_W-1:0] PAGE_SHIFT_RST = 5'd8;
	localparam logic [PAGE_CNT_W-1:0]   PAGE_CNT_RST   = 9'd256;
	localparam logic [FRAME_CNT_W-1:0]  FRAME_CNT_RST  = 8'd128;

	localparam logic [PAGE_SHIFT_W-1:0] SHIFT_MIN = 5'd4;
	localparam logic [PAGE_SHIFT_W-1:0] SHIFT_MAX = 5'd16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PAGE_SHIFT  = 2'd0,
		CFG_PAGE_COUNT  = 2'd1,
		CFG_FRAME_COUNT = 2'd2
	} cfg_idx_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear_step;
		logic load_addr;
		logic check;
		logic lookup;
		logic scan_start;
		logic scan_step;
		logic evict;
		logic install;
		logic publish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_last;
		logic range_err;
		logic hit;
		logic fresh;
		logic scan_done;
	} stat_t;

	function automatic logic [PAGE_SHIFT_W-1:0] clamp_shift(input logic [PAGE_SHIFT_W-1:0] v);
		logic [PAGE_SHIFT_W-1:0] r;
		if (v < SHIFT_MIN) begin
			r = SHIFT_MIN;
		end else if (v > SHIFT_MAX) begin
			r = SHIFT_MAX;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

### design/ptl_ram.sv
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module ptl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### design/ptl_ctrl.sv
// ----------------------------------------------------------------------------
// Page translation controller
// Runs the reset clear sweep, then sequences one request at a time through check,
// lookup, LRU scan, eviction and install; owns the input ready and output valid.
// ----------------------------------------------------------------------------
module ptl_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  ptl_pkg::stat_t stat,
	output ptl_pkg::cmd_t  cmd
);

	typedef enum logic [7:0] {
		ST_CLEAR   = 8'b0000_0001,
		ST_IDLE    = 8'b0000_0010,
		ST_CHECK   = 8'b0000_0100,
		ST_LOOKUP  = 8'b0000_1000,
		ST_SCAN    = 8'b0001_0000,
		ST_EVICT   = 8'b0010_0000,
		ST_INSTALL = 8'b0100_0000,
		ST_FINISH  = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (stat.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_addr = 1'b1;
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				state_d = stat.range_err ? ST_FINISH : ST_LOOKUP;
			end
			ST_LOOKUP: begin
				cmd.lookup = 1'b1;
				if (stat.hit || stat.fresh) begin
					state_d = ST_FINISH;
				end else begin
					cmd.scan_start = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_done) begin
					state_d = ST_EVICT;
				end
			end
			ST_EVICT: begin
				cmd.evict = 1'b1;
				state_d = ST_INSTALL;
			end
			ST_INSTALL: begin
				cmd.install = 1'b1;
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) begin
					cmd.publish = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### design/ptl_datapath.sv
// ----------------------------------------------------------------------------
// Page translation datapath
// Configuration registers, page table RAM, access clock, frame allocator,
// LRU scan and result registers.
// ----------------------------------------------------------------------------
module ptl_datapath #(
	parameter int MAX_PAGES  = ptl_pkg::MAX_PAGES,
	parameter int MAX_FRAMES = ptl_pkg::MAX_FRAMES,
	parameter int ADDR_BITS  = ptl_pkg::ADDR_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ptl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ptl_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [ADDR_BITS-1:0]           logical_address,
	input  ptl_pkg::cmd_t                  cmd,
	output ptl_pkg::stat_t                 stat,
	output logic [ADDR_BITS-1:0]           physical_address,
	output logic                           page_fault,
	output logic                           evicted_valid,
	output logic [$clog2(MAX_PAGES)-1:0]   evicted_page,
	output logic                           range_error
);

	localparam int PAGE_W  = $clog2(MAX_PAGES);
	localparam int PCNT_W  = $clog2(MAX_PAGES + 1);
	localparam int FCNT_W  = $clog2(MAX_FRAMES + 1);
	localparam int FRAME_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int STAMP_W = ptl_pkg::STAMP_W;
	localparam int ENTRY_W = 1 + FRAME_W + STAMP_W;

	// Configuration registers.
	logic [ptl_pkg::PAGE_SHIFT_W-1:0] page_shift_q;
	logic [ptl_pkg::PAGE_CNT_W-1:0]   page_count_q;
	logic [ptl_pkg::FRAME_CNT_W-1:0]  frame_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_shift_q  <= ptl_pkg::PAGE_SHIFT_RST;
			page_count_q  <= ptl_pkg::PAGE_CNT_RST;
			frame_count_q <= ptl_pkg::FRAME_CNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ptl_pkg::CFG_PAGE_SHIFT:  page_shift_q  <= cfg_data[ptl_pkg::PAGE_SHIFT_W-1:0];
				ptl_pkg::CFG_PAGE_COUNT:  page_count_q  <= cfg_data[ptl_pkg::PAGE_CNT_W-1:0];
				ptl_pkg::CFG_FRAME_COUNT: frame_count_q <= cfg_data[ptl_pkg::FRAME_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Registers are kept as written and clamped where used.
	logic [ptl_pkg::PAGE_SHIFT_W-1:0] shift_c;
	logic [PCNT_W-1:0]                pcount_c;
	logic [FCNT_W-1:0]                fcount_c;

	assign shift_c = ptl_pkg::clamp_shift(page_shift_q);

	always_comb begin
		if (page_count_q == '0) begin
			pcount_c = PCNT_W'(1);
		end else if (32'(page_count_q) > 32'(MAX_PAGES)) begin
			pcount_c = PCNT_W'(MAX_PAGES);
		end else begin
			pcount_c = PCNT_W'(page_count_q);
		end
		if (frame_count_q == '0) begin
			fcount_c = FCNT_W'(1);
		end else if (32'(frame_count_q) > 32'(MAX_FRAMES)) begin
			fcount_c = FCNT_W'(MAX_FRAMES);
		end else begin
			fcount_c = FCNT_W'(frame_count_q);
		end
	end

	// Request address and page number.
	logic [ADDR_BITS-1:0] addr_q;
	logic [ADDR_BITS-1:0] page_full;
	logic [PAGE_W-1:0]    page_q;
	logic                 range_hit;

	assign page_full = addr_q >> shift_c;
	assign range_hit = page_full >= ADDR_BITS'(pcount_c);

	// Page table RAM: {valid, frame, stamp} per page.
	logic               ram_we;
	logic [PAGE_W-1:0]  ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [PAGE_W-1:0]  ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;
	logic               rd_valid;
	logic [FRAME_W-1:0] rd_frame;
	logic [STAMP_W-1:0] rd_stamp;

	assign rd_valid = ram_rdata[ENTRY_W-1];
	assign rd_frame = ram_rdata[STAMP_W +: FRAME_W];
	assign rd_stamp = ram_rdata[STAMP_W-1:0];

	ptl_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_PAGES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Control state: clear sweep, access clock, allocator, scan.
	localparam int SCAN_W = $clog2(MAX_PAGES + 1);

	logic [PAGE_W-1:0]  clr_idx_q;
	logic [STAMP_W-1:0] clock_q;
	logic [STAMP_W-1:0] clock_next;
	logic [FCNT_W-1:0]  handed_q;
	logic [SCAN_W-1:0]  scan_idx_q;
	logic               scan_issue;
	logic               scan_pend_s1;
	logic [PAGE_W-1:0]  scan_pidx_s1;
	logic               best_found_q;
	logic [PAGE_W-1:0]  best_page_q;
	logic [FRAME_W-1:0] best_frame_q;
	logic [STAMP_W-1:0] best_stamp_q;
	logic               best_take;
	logic               fresh;

	assign clock_next = (clock_q == '1) ? clock_q : clock_q + STAMP_W'(1);
	assign fresh      = handed_q < fcount_c;
	assign scan_issue = scan_idx_q != SCAN_W'(MAX_PAGES);
	assign best_take  = cmd.scan_step && scan_pend_s1 && rd_valid &&
		(!best_found_q || rd_stamp < best_stamp_q);

	assign ram_raddr = cmd.scan_step ? scan_idx_q[PAGE_W-1:0] : page_full[PAGE_W-1:0];

	assign stat.clear_last = clr_idx_q == PAGE_W'(MAX_PAGES - 1);
	assign stat.range_err  = range_hit;
	assign stat.hit        = rd_valid;
	assign stat.fresh      = fresh;
	assign stat.scan_done  = !scan_issue && !scan_pend_s1;

	// Result registers of the request in flight.
	logic [FRAME_W-1:0] res_frame_q;
	logic               res_fault_q;
	logic               res_ev_valid_q;
	logic [PAGE_W-1:0]  res_ev_page_q;
	logic               res_range_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = page_q;
		ram_wdata = '0;
		if (cmd.clear_step) begin
			ram_we    = 1'b1;
			ram_waddr = clr_idx_q;
		end else if (cmd.lookup) begin
			if (rd_valid) begin
				ram_we    = 1'b1;
				ram_wdata = {1'b1, rd_frame, clock_next};
			end else if (fresh) begin
				ram_we    = 1'b1;
				ram_wdata = {1'b1, FRAME_W'(handed_q), clock_next};
			end
		end else if (cmd.evict) begin
			ram_we    = best_found_q;
			ram_waddr = best_page_q;
			ram_wdata = {1'b0, best_frame_q, best_stamp_q};
		end else if (cmd.install) begin
			ram_we    = 1'b1;
			ram_wdata = {1'b1, res_frame_q, clock_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q    <= '0;
			clock_q      <= '0;
			handed_q     <= '0;
			scan_idx_q   <= '0;
			scan_pend_s1 <= 1'b0;
			best_found_q <= 1'b0;
		end else begin
			if (cmd.clear_step) begin
				clr_idx_q <= clr_idx_q + PAGE_W'(1);
			end
			if (cmd.lookup) begin
				clock_q <= clock_next;
				if (!rd_valid && fresh) begin
					handed_q <= handed_q + FCNT_W'(1);
				end
			end
			if (cmd.scan_start) begin
				scan_idx_q   <= '0;
				scan_pend_s1 <= 1'b0;
				best_found_q <= 1'b0;
			end else if (cmd.scan_step) begin
				scan_pend_s1 <= scan_issue;
				if (scan_issue) begin
					scan_idx_q <= scan_idx_q + SCAN_W'(1);
				end
				if (best_take) begin
					best_found_q <= 1'b1;
				end
			end
		end
	end

	// Payload registers, no reset needed.
	always_ff @(posedge clk) begin
		if (cmd.load_addr) begin
			addr_q <= logical_address;
		end
		if (cmd.scan_step) begin
			scan_pidx_s1 <= scan_idx_q[PAGE_W-1:0];
		end
		if (best_take) begin
			best_page_q  <= scan_pidx_s1;
			best_frame_q <= rd_frame;
			best_stamp_q <= rd_stamp;
		end
		if (cmd.check) begin
			page_q         <= page_full[PAGE_W-1:0];
			res_range_q    <= range_hit;
			res_fault_q    <= 1'b0;
			res_ev_valid_q <= 1'b0;
			res_ev_page_q  <= '0;
			res_frame_q    <= '0;
		end
		if (cmd.lookup) begin
			if (rd_valid) begin
				res_frame_q <= rd_frame;
			end else begin
				res_fault_q <= 1'b1;
				if (fresh) begin
					res_frame_q <= FRAME_W'(handed_q);
				end
			end
		end
		if (cmd.evict) begin
			if (best_found_q) begin
				res_frame_q    <= best_frame_q;
				res_ev_valid_q <= 1'b1;
				res_ev_page_q  <= best_page_q;
			end else begin
				res_frame_q <= '0;
			end
		end
	end

	// Output register.
	logic [ADDR_BITS-1:0] phys;
	logic [ADDR_BITS-1:0] phys_q;
	logic                 fault_q;
	logic                 ev_valid_q;
	logic [PAGE_W-1:0]    ev_page_q;
	logic                 range_q;

	assign phys = (ADDR_BITS'(res_frame_q) << shift_c) |
		(addr_q & ~({ADDR_BITS{1'b1}} << shift_c));

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			phys_q     <= res_range_q ? '0 : phys;
			fault_q    <= res_fault_q;
			ev_valid_q <= res_ev_valid_q;
			ev_page_q  <= res_ev_page_q;
			range_q    <= res_range_q;
		end
	end

	assign physical_address = phys_q;
	assign page_fault       = fault_q;
	assign evicted_valid    = ev_valid_q;
	assign evicted_page     = ev_page_q;
	assign range_error      = range_q;

endmodule

### design/page_translate_lru_unit.sv
// ----------------------------------------------------------------------------
// Page translation unit with LRU frame replacement
// Translates a logical byte address into a physical address through a page
// table, handing out free frames first and then evicting the least recently
// used page. Channels: a configuration write channel (cfg_valid/cfg_ready,
// cfg_index, cfg_data, always ready), the request input (in_valid/in_ready,
// logical_address) and the result output (out_valid/out_ready, five fields).
// One request is worked on at a time. An out-of-range page finishes after the
// check, a hit or a miss served by a free frame after the lookup; a miss that
// evicts walks the page table RAM one entry a cycle, as the RAM has a single read
// port. After reset the page table is swept invalid, one entry a cycle; no
// request is taken meanwhile, configuration writes are.
// The result sits in an output register; while the receiver stalls, the unit
// still accepts and processes the next request and holds it until the output
// register is free. Configuration must only be written while the unit is idle.
// ----------------------------------------------------------------------------
`include "page_translate_lru_unit_macros.svh"

module page_translate_lru_unit #(
	parameter int MAX_PAGES  = ptl_pkg::MAX_PAGES,
	parameter int MAX_FRAMES = ptl_pkg::MAX_FRAMES,
	parameter int ADDR_BITS  = ptl_pkg::ADDR_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ptl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ptl_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [ADDR_BITS-1:0]           logical_address,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [ADDR_BITS-1:0]           physical_address,
	output logic                           page_fault,
	output logic                           evicted_valid,
	output logic [$clog2(MAX_PAGES)-1:0]   evicted_page,
	output logic                           range_error
);

	ptl_pkg::cmd_t  cmd;
	ptl_pkg::stat_t stat;

	// Registers are plain flops, so a configuration write is never stalled.
	assign cfg_ready = 1'b1;

	ptl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ptl_datapath #(
		.MAX_PAGES (MAX_PAGES),
		.MAX_FRAMES(MAX_FRAMES),
		.ADDR_BITS (ADDR_BITS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_valid && cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.logical_address (logical_address),
		.cmd             (cmd),
		.stat            (stat),
		.physical_address(physical_address),
		.page_fault      (page_fault),
		.evicted_valid   (evicted_valid),
		.evicted_page    (evicted_page),
		.range_error     (range_error)
	);

	// A request in work blocks the next one.
	`PTL_ASSERT_NXT(a_accept_drops_ready, clk, arst_n, in_valid && in_ready, !in_ready)
	// A result is only loaded into a free output register.
	`PTL_ASSERT_IMP(a_publish_slot_free, clk, arst_n, cmd.publish, !out_valid || out_ready)
	// A loaded result is offered in the following cycle.
	`PTL_ASSERT_NXT(a_publish_shows, clk, arst_n, cmd.publish, out_valid)
	// At most one source drives the table write port.
	`PTL_ASSERT_IMP(a_one_ram_writer, clk, arst_n, 1'b1, ($onehot0({cmd.clear_step, cmd.lookup, cmd.evict, cmd.install})))

endmodule
